// File: rtl/sfms_pkg.sv
package sfms_pkg;

	// capacities
	localparam int MAX_PATTERN = 64;
	localparam int MAX_TEXT    = 65536;

	// widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int CNT_W  = $clog2(MAX_TEXT + 2);
	localparam int IDX_W  = 16;

	localparam logic [LEN_W-1:0] PAT_FULL  = LEN_W'(MAX_PATTERN);
	localparam logic [CNT_W-1:0] TEXT_FULL = CNT_W'(MAX_TEXT);
	localparam logic [CNT_W-1:0] TEXT_OVF  = CNT_W'(MAX_TEXT + 1);

	typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_row_t;

	// item commands
	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_PATTERN = 2'd1,
		CMD_TEXT    = 2'd2,
		CMD_END     = 2'd3
	} cmd_t;

	// result codes
	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID   = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

endpackage

// File: rtl/sfms_window_cmp.sv
module sfms_window_cmp
	import sfms_pkg::*;
(
	input  byte_row_t              pattern_aligned,
	input  logic [MAX_PATTERN-1:0] pattern_mask,
	input  byte_row_t              window,
	output logic                   hit
);

	logic [MAX_PATTERN-1:0] lane_ok;

	// one byte compare per window lane, unused lanes always agree
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			lane_ok[j] = !pattern_mask[j] || (pattern_aligned[j] == window[j]);
		end
	end

	assign hit = &lane_ok;

endmodule

// File: rtl/substring_first_match_search_top.sv
// First-match substring search over a streamed byte text.
// Input channel (in_valid/in_ready, command, data_byte): clear, append a
// pattern byte, stream a text byte, or end the text. Output channel
// (out_valid/out_ready, status, match_index) carries one result for each
// end-of-text item and nothing for the other commands.
// Each transfer is registered in the input register, then processed there:
// the pattern is compared against the newest text bytes with one parallel
// compare across all 64 window lanes, so one item per cycle is sustained
// unless an end-of-text item stalls. A result passes the input register
// and then the output register before the receiver can take it.
// The output register holds the result while the receiver stalls; items
// that give no result keep flowing, and an end-of-text item waits in the
// input register only while the previous result is still not taken.
// Reset empties the pipeline and the search state; a clear item empties
// only the search state. The pattern bytes themselves are not reset and
// are never read beyond the loaded length.
module substring_first_match_search_top
	import sfms_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   command,
	input  logic [7:0]   data_byte,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [1:0]   status,
	output logic [15:0]  match_index
);

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               advance;

	byte_row_t              pattern_q;
	logic [MAX_PATTERN-1:0] pattern_mask_q;
	logic [LEN_W-1:0]       pattern_len_q;
	logic                   pattern_ovf_q;
	byte_row_t              window_q;
	byte_row_t              window_next;
	logic [CNT_W-1:0]       text_count_q;
	logic [CNT_W-1:0]       count_next;
	logic                   match_seen_q;
	logic [IDX_W-1:0]       match_pos_q;
	logic                   hit;
	logic                   new_match;

	logic                   out_valid_q;
	status_t                status_q;
	logic [IDX_W-1:0]       match_index_q;
	status_t                status_next;
	logic [IDX_W-1:0]       index_next;

	// handshake: stage 1 stalls only on an end item facing a full output that is not being taken
	assign advance  = valid_s1 && ((cmd_s1 != CMD_END) || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd_t'(command);
			byte_s1 <= data_byte;
		end
	end

	// window after this text byte, newest in lane 0
	assign window_next = {window_q[MAX_PATTERN-2:0], byte_s1};
	assign count_next  = text_count_q + CNT_W'(1);

	sfms_window_cmp u_cmp (
		.pattern_aligned (pattern_q),
		.pattern_mask    (pattern_mask_q),
		.window          (window_next),
		.hit             (hit)
	);

	assign new_match = !match_seen_q && (pattern_len_q != '0) && !pattern_ovf_q &&
		(count_next >= CNT_W'(pattern_len_q)) && hit;

	// search state control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mask_q <= '0;
			pattern_len_q  <= '0;
			pattern_ovf_q  <= 1'b0;
			text_count_q   <= '0;
			match_seen_q   <= 1'b0;
			match_pos_q    <= '0;
		end else if (advance) begin
			unique case (cmd_s1)
				CMD_CLEAR: begin
					pattern_mask_q <= '0;
					pattern_len_q  <= '0;
					pattern_ovf_q  <= 1'b0;
					text_count_q   <= '0;
					match_seen_q   <= 1'b0;
					match_pos_q    <= '0;
				end
				CMD_PATTERN: begin
					if (text_count_q == '0) begin
						if (pattern_len_q < PAT_FULL) begin
							pattern_mask_q <= {pattern_mask_q[MAX_PATTERN-2:0], 1'b1};
							pattern_len_q  <= pattern_len_q + LEN_W'(1);
						end else begin
							pattern_ovf_q <= 1'b1;
						end
					end
				end
				CMD_TEXT: begin
					if (text_count_q >= TEXT_FULL) begin
						text_count_q <= TEXT_OVF;
					end else begin
						text_count_q <= count_next;
						if (new_match) begin
							match_seen_q <= 1'b1;
							match_pos_q  <= IDX_W'(count_next - CNT_W'(pattern_len_q));
						end
					end
				end
				CMD_END: begin
				end
				default: begin
				end
			endcase
		end
	end

	// pattern and window bytes, pattern kept aligned to the window lanes
	always_ff @(posedge clk) begin
		if (advance) begin
			if ((cmd_s1 == CMD_PATTERN) && (text_count_q == '0) &&
				(pattern_len_q < PAT_FULL)) begin
				pattern_q <= {pattern_q[MAX_PATTERN-2:0], byte_s1};
			end
			if ((cmd_s1 == CMD_TEXT) && (text_count_q < TEXT_FULL)) begin
				window_q <= window_next;
			end
		end
	end

	// outcome at end of text
	always_comb begin
		index_next = '0;
		priority if ((pattern_len_q == '0) || pattern_ovf_q || (text_count_q == '0)) begin
			status_next = ST_INVALID;
		end else if (text_count_q > TEXT_FULL) begin
			status_next = ST_OVERFLOW;
		end else if (match_seen_q) begin
			status_next = ST_FOUND;
			index_next  = match_pos_q;
		end else begin
			status_next = ST_NOT_FOUND;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (cmd_s1 == CMD_END)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (cmd_s1 == CMD_END)) begin
			status_q      <= status_next;
			match_index_q <= index_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_index = match_index_q;

endmodule
